// File: rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Types and constants of the search transposition table: request and
// response beats, bound flags and operation codes.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam logic       OP_PROBE   = 1'b0;
   localparam logic       OP_STORE   = 1'b1;

   localparam logic [1:0] FLAG_EXACT = 2'd0;
   localparam logic [1:0] FLAG_LOWER = 2'd1;
   localparam logic [1:0] FLAG_UPPER = 2'd2;
   localparam logic [1:0] FLAG_NONE  = 2'd3;

   localparam int HASH_W = 64;

   typedef struct packed {
      logic               operation;
      logic [63:0]        position_hash;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic signed [15:0] alpha_before;
      logic [7:0]         search_depth;
      logic [15:0]        found_move;
      logic signed [15:0] found_score;
   } tst_req_type;

   typedef struct packed {
      logic               hit;
      logic               cutoff;
      logic [1:0]         entry_flag;
      logic [7:0]         entry_depth;
      logic [15:0]        entry_move;
      logic signed [15:0] entry_score;
   } tst_rsp_type;

   function automatic logic [1:0] bound_flag(input tst_req_type r);
      logic [1:0] f;
      if (r.found_score >= r.beta) begin
         f = FLAG_LOWER;
      end else if (r.alpha != r.alpha_before) begin
         f = FLAG_EXACT;
      end else begin
         f = FLAG_UPPER;
      end
      return f;
   endfunction

endpackage

// File: rtl/search_transposition_table.sv
// Response path: for power-of-two TABLE_ENTRIES a store answers in the cycle
//   after its beat, a probe after one memory read; otherwise the slot index
//   remainder over four 16-bit hash digits comes first.
// Throughput: one store per cycle while responses drain (power of two); no new
//   request is taken while a probe or remainder runs. Reset: a clear pass
//   writes every slot, one per cycle; req_ready stays low until it ends.
// ----------------------------------------------------------------------------
// search_transposition_table
// Direct-mapped always-replace transposition table held in one synchronous
// memory; probes report hit, entry fields and cutoff, stores overwrite.
// ----------------------------------------------------------------------------
module search_transposition_table #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int KEY_BITS      = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tst_pkg::tst_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tst_pkg::tst_rsp_type rsp_payload
);
   import tst_pkg::*;

   localparam int  IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam bit  IS_POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam int  WORD_W   = KEY_BITS + 2 + 8 + 16 + 16;
   localparam int  DIG_W    = 16;
   localparam int  X_W      = IDX_W + DIG_W;
   localparam int  T_W      = DIG_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [T_W-1:0]   RECIP    = T_W'((64'd1 << X_W) / 64'(TABLE_ENTRIES));
   localparam logic [IDX_W+1:0] ONE_N    = (IDX_W + 2)'(TABLE_ENTRIES);
   localparam logic [IDX_W+1:0] TWO_N    = (IDX_W + 2)'(2 * TABLE_ENTRIES);
   localparam logic [1:0]       DIV_LAST = 2'd3;
   localparam logic [WORD_W-1:0] RESET_WORD =
      {{KEY_BITS{1'b0}}, FLAG_NONE, 8'd0, 16'd0, 16'd0};

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_DIV     = 3'd2;
   localparam logic [2:0] ST_ACCESS  = 3'd3;
   localparam logic [2:0] ST_RESULT  = 3'd4;
   localparam logic [2:0] ST_DIV_SUB = 3'd5;
   localparam logic [2:0] ST_DIV_FIX = 3'd6;

   logic [WORD_W-1:0] mem [TABLE_ENTRIES];

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   tst_req_type        req_ff, req_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [HASH_W-1:0]  div_hash_ff, div_hash_in;
   logic [1:0]         div_cnt_ff, div_cnt_in;
   logic [T_W-1:0]     quo_ff, quo_in;
   logic [IDX_W+1:0]   part_ff, part_in;
   logic [WORD_W-1:0]  rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tst_rsp_type        rsp_ff, rsp_in;

   logic               req_fire;
   logic               rsp_free;
   tst_req_type        src;
   logic [IDX_W-1:0]   acc_idx;
   logic               acc_store;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [WORD_W-1:0]  wr_data;
   logic [X_W-1:0]     div_x;
   logic [2*T_W-1:0]   div_prod;
   logic [X_W+1:0]     div_qn;
   logic [X_W+1:0]     div_diff;
   logic [KEY_BITS-1:0] rd_key;
   logic [1:0]         rd_flag;
   logic [7:0]         rd_depth;
   logic [15:0]        rd_move;
   logic signed [15:0] rd_score;
   logic               probe_hit;
   logic               probe_cut;
   tst_rsp_type        store_rsp;
   tst_rsp_type        probe_rsp;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign src     = (state_ff == ST_IDLE) ? req_payload : req_ff;
   assign acc_idx = (state_ff == ST_IDLE) ? req_payload.position_hash[IDX_W-1:0] : rem_ff;
   assign acc_store = ((state_ff == ST_IDLE) && req_fire && IS_POW2
                       && (req_payload.operation == OP_STORE))
                   || ((state_ff == ST_ACCESS) && (req_ff.operation == OP_STORE));

   assign wr_en   = (state_ff == ST_CLEAR) || acc_store;
   assign wr_idx  = (state_ff == ST_CLEAR) ? clr_ff : acc_idx;
   assign wr_data = (state_ff == ST_CLEAR) ? RESET_WORD
                  : {src.position_hash[KEY_BITS-1:0], bound_flag(src), src.search_depth,
                     src.found_move, src.found_score};

   assign div_x    = {rem_ff, div_hash_ff[HASH_W-1 -: DIG_W]};
   assign div_prod = (2 * T_W)'(div_x[X_W-1 -: T_W]) * (2 * T_W)'(RECIP);
   assign div_qn   = (X_W + 2)'(quo_ff) * (X_W + 2)'(ONE_N);
   assign div_diff = {2'b00, div_x} - div_qn;

   assign rd_key   = rd_ff[WORD_W-1 -: KEY_BITS];
   assign rd_flag  = rd_ff[41:40];
   assign rd_depth = rd_ff[39:32];
   assign rd_move  = rd_ff[31:16];
   assign rd_score = $signed(rd_ff[15:0]);

   assign probe_hit = rd_key == req_ff.position_hash[KEY_BITS-1:0];

   always_comb begin
      probe_cut = 1'b0;
      if (probe_hit && (rd_depth >= req_ff.search_depth)) begin
         case (rd_flag)
            FLAG_EXACT: probe_cut = 1'b1;
            FLAG_LOWER: probe_cut = rd_score >= req_ff.beta;
            FLAG_UPPER: probe_cut = rd_score <= req_ff.alpha;
            default:    probe_cut = 1'b0;
         endcase
      end
   end

   always_comb begin
      store_rsp            = '0;
      store_rsp.entry_flag = bound_flag(src);
      probe_rsp.hit         = probe_hit;
      probe_rsp.cutoff      = probe_cut;
      probe_rsp.entry_flag  = rd_flag;
      probe_rsp.entry_depth = rd_depth;
      probe_rsp.entry_move  = rd_move;
      probe_rsp.entry_score = rd_score;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      rem_in       = rem_ff;
      div_hash_in  = div_hash_ff;
      div_cnt_in   = div_cnt_ff;
      quo_in       = quo_ff;
      part_in      = part_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (acc_store) begin
         rsp_valid_in = 1'b1;
         rsp_in       = store_rsp;
      end else if (state_ff == ST_RESULT) begin
         rsp_valid_in = 1'b1;
         rsp_in       = probe_rsp;
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               req_in      = req_payload;
               rem_in      = '0;
               div_hash_in = req_payload.position_hash;
               div_cnt_in  = '0;
               if (!IS_POW2) begin
                  state_in = ST_DIV;
               end else if (req_payload.operation == OP_PROBE) begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_DIV: begin
            quo_in   = div_prod[2*T_W-1 -: T_W];
            state_in = ST_DIV_SUB;
         end
         ST_DIV_SUB: begin
            part_in  = div_diff[IDX_W+1:0];
            state_in = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            if (part_ff >= TWO_N) begin
               rem_in = IDX_W'(part_ff - TWO_N);
            end else if (part_ff >= ONE_N) begin
               rem_in = IDX_W'(part_ff - ONE_N);
            end else begin
               rem_in = part_ff[IDX_W-1:0];
            end
            div_hash_in = {div_hash_ff[HASH_W-DIG_W-1:0], {DIG_W{1'b0}}};
            div_cnt_in  = div_cnt_ff + 2'd1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_ACCESS;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_ACCESS: begin
            state_in = (req_ff.operation == OP_PROBE) ? ST_RESULT : ST_IDLE;
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_ff <= mem[acc_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rem_ff      <= rem_in;
      div_hash_ff <= div_hash_in;
      div_cnt_ff  <= div_cnt_in;
      quo_ff      <= quo_in;
      part_ff     <= part_in;
      rsp_ff      <= rsp_in;
   end

   a_result_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT) |-> !rsp_valid_ff)
      else $error("probe result with output slot occupied");

   a_cut_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.cutoff || rsp_ff.hit))
      else $error("cutoff without hit");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && !acc_store))
      else $error("activity during clear pass");

   a_probe_goes_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && IS_POW2 && (req_payload.operation == OP_PROBE))
      |=> (state_ff == ST_RESULT))
      else $error("probe did not reach result stage");

endmodule

// File: tb/search_transposition_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// search_transposition_table_tb
// Self-checking bench for the transposition table. A queue of probe and store
// beats, directed corner cases followed by random store and probe sequences
// over a small pool of hashes, feeds a valid/ready driver. A shadow copy of
// the table predicts every response, and the monitor compares each response
// beat field by field. Both sides idle at random, and the receiver holds off
// for a long stretch once so that the table backs up.
// ----------------------------------------------------------------------------
module search_transposition_table_tb;
   import tst_pkg::*;

   localparam int ENTRIES     = 4096;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 13;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tst_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tst_rsp_type rsp_payload;

   tst_req_type pending_beats[$];
   tst_rsp_type expected_answers[$];

   logic [31:0]        shadow_key   [ENTRIES];
   logic [1:0]         shadow_flag  [ENTRIES];
   logic [7:0]         shadow_depth [ENTRIES];
   logic [15:0]        shadow_move  [ENTRIES];
   logic signed [15:0] shadow_score [ENTRIES];

   logic req_beat = 1'b0;
   int   req_sent = 0;
   int   rsp_count = 0;
   int   mismatches = 0;
   int   cycle_count = 0;
   int   hold_cycles = 0;
   logic hold_done = 1'b0;

   search_transposition_table DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_key[i]   = '0;
         shadow_flag[i]  = FLAG_NONE;
         shadow_depth[i] = '0;
         shadow_move[i]  = '0;
         shadow_score[i] = '0;
      end
   end

   task automatic predict_table_access(input tst_req_type r, output tst_rsp_type a);
      logic [11:0]        idx;
      logic [31:0]        key;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic signed [15:0] score;
      logic signed [15:0] held;
      logic [1:0]         flag;
      idx   = r.position_hash[11:0];
      key   = r.position_hash[31:0];
      alpha = r.alpha;
      beta  = r.beta;
      score = r.found_score;
      a     = '0;
      if (r.operation == OP_STORE) begin
         if (score >= beta) begin
            flag = FLAG_LOWER;
         end else if (r.alpha != r.alpha_before) begin
            flag = FLAG_EXACT;
         end else begin
            flag = FLAG_UPPER;
         end
         shadow_key[idx]   = key;
         shadow_flag[idx]  = flag;
         shadow_depth[idx] = r.search_depth;
         shadow_move[idx]  = r.found_move;
         shadow_score[idx] = score;
         a.entry_flag      = flag;
      end else begin
         held          = shadow_score[idx];
         a.hit         = shadow_key[idx] == key;
         a.entry_flag  = shadow_flag[idx];
         a.entry_depth = shadow_depth[idx];
         a.entry_move  = shadow_move[idx];
         a.entry_score = held;
         if (a.hit && shadow_depth[idx] >= r.search_depth) begin
            case (shadow_flag[idx])
               FLAG_EXACT: a.cutoff = 1'b1;
               FLAG_LOWER: a.cutoff = held >= beta;
               FLAG_UPPER: a.cutoff = held <= alpha;
               default:    a.cutoff = 1'b0;
            endcase
         end
      end
   endtask

   function automatic tst_req_type make_req(input logic op, input logic [63:0] hash,
                                            input logic signed [15:0] alpha,
                                            input logic signed [15:0] beta,
                                            input logic signed [15:0] alpha_before,
                                            input logic [7:0] depth, input logic [15:0] move,
                                            input logic signed [15:0] score);
      tst_req_type r;
      r.operation     = op;
      r.position_hash = hash;
      r.alpha         = alpha;
      r.beta          = beta;
      r.alpha_before  = alpha_before;
      r.search_depth  = depth;
      r.found_move    = move;
      r.found_score   = score;
      return r;
   endfunction

   // small values make the bound tests flip often
   function automatic logic signed [15:0] rand_bound();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 1) ? 32767 : -32768;
         default: v = int'($urandom_range(0, 12)) - 6;
      endcase
      return 16'(v);
   endfunction

   function automatic logic [7:0] rand_depth();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 6));
   endfunction

   initial begin : stimulus
      logic [63:0] pool[$];
      logic [63:0] h;
      tst_req_type r;
      int          pick;
      int          total;
      // directed corner cases
      pending_beats.push_back(make_req(OP_PROBE, 64'hA5A5_5A5A_0000_0000, 0, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, -32768, 32767,
                                       -32768, 255, 16'hFFFF, 32767));
      pending_beats.push_back(make_req(OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, -32768, 32767,
                                       0, 255, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, -32768,
                                       0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_STORE, 64'h0123_4567_89AB_C123, 5, 32767, 4, 10,
                                       16'h1234, -32768));
      pending_beats.push_back(make_req(OP_PROBE, 64'h0123_4567_89AB_C123, 0, 0, 0, 10, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'h0123_4567_89AB_C123, 0, 0, 0, 11, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'h0123_4567_89BB_C123, 0, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'hFEDC_BA98_89AB_C123, 0, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_STORE, 64'h0000_0000_0000_0001, -32768, 0, -32768,
                                       0, 0, -100));
      pending_beats.push_back(make_req(OP_PROBE, 64'h0000_0000_0000_0001, -100, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'h0000_0000_0000_0001, -101, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_STORE, 64'hDEAD_BEEF_0000_0800, 0, 0, 0, 128,
                                       16'h8000, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'hDEAD_BEEF_0000_0800, 0, 0, 0, 128, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'hDEAD_BEEF_0000_0800, 0, 1, 0, 128, 0, 0));
      pending_beats.push_back(make_req(OP_STORE, 64'h0000_0000_5555_5000, 7, 32767, -7, 3,
                                       16'h0F0F, 12));
      pending_beats.push_back(make_req(OP_PROBE, 64'hA5A5_5A5A_0000_0000, 0, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_req(OP_STORE, 64'hDEAD_BEEF_0000_0800, 32767, 32767, 32767,
                                       1, 16'h00FF, 32766));
      pending_beats.push_back(make_req(OP_PROBE, 64'hDEAD_BEEF_0000_0800, 32767, 0, 0, 1, 0, 0));
      pending_beats.push_back(make_req(OP_PROBE, 64'h0123_4567_89AB_C123, 32767, -32768, 0, 0,
                                       0, 0));
      pool = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_C123, 64'h1, 64'hDEAD_BEEF_0000_0800};
      // random store and probe sequences over a pool of live hashes
      for (int n = 0; n < 800; n++) begin
         pick = $urandom_range(0, 99);
         h = pool[$urandom_range(0, pool.size() - 1)];
         r = make_req(OP_PROBE, h, rand_bound(), rand_bound(), rand_bound(), rand_depth(),
                      16'($urandom), rand_bound());
         if (pick < 40) begin
            r.operation = OP_STORE;
            if ($urandom_range(0, 99) < 40) begin
               r.position_hash = {$urandom, $urandom};
               pool.push_back(r.position_hash);
               if (pool.size() > 48) begin
                  void'(pool.pop_front());
               end
            end
            if ($urandom_range(0, 1)) begin
               r.alpha_before = r.alpha;
            end
         end else if (pick < 75) begin
            if ($urandom_range(0, 3) == 0) begin
               r.position_hash = h ^ {$urandom, 32'h0};
            end
         end else if (pick < 88) begin
            r.position_hash = h ^ (64'h1 << $urandom_range(12, 31));
         end else begin
            r.position_hash = {$urandom, $urandom};
         end
         pending_beats.push_back(r);
      end
      total = pending_beats.size();
      @(negedge clock);
      while (rsp_count < total) begin
         @(negedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // predict at the accepting edge, in beat order
   always @(posedge clock) begin : accept
      tst_rsp_type a;
      req_beat <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         predict_table_access(req_payload, a);
         expected_answers.push_back(a);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (pending_beats.size() != 0 &&
             ((req_sent >= 300 && req_sent < 450) || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_beats.pop_front();
            req_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // hold off the receiver once for a long stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && rsp_count >= 400) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= 200;
         hold_done   <= 1'b1;
      end else begin
         rsp_ready <= (rsp_count >= 650 && rsp_count < 800) ||
                      $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin : monitor
      tst_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d with no beat outstanding: %p", rsp_count, rsp_payload);
            end
         end else begin
            want = expected_answers.pop_front();
            if (rsp_payload.hit !== want.hit || rsp_payload.cutoff !== want.cutoff ||
                rsp_payload.entry_flag !== want.entry_flag ||
                rsp_payload.entry_depth !== want.entry_depth ||
                rsp_payload.entry_move !== want.entry_move ||
                rsp_payload.entry_score !== want.entry_score) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d: expected hit %b cutoff %b flag %0d depth %0d",
                           rsp_count, want.hit, want.cutoff, want.entry_flag,
                           want.entry_depth, " move %h score %0d", want.entry_move,
                           want.entry_score);
                  $display("response %0d: actual   hit %b cutoff %b flag %0d depth %0d",
                           rsp_count, rsp_payload.hit, rsp_payload.cutoff,
                           rsp_payload.entry_flag, rsp_payload.entry_depth,
                           " move %h score %0d", rsp_payload.entry_move,
                           rsp_payload.entry_score);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
